FILE: design/iir_third_order_lowpass_three_axis_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis third-order low-pass filter
// Shared property wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef IIR_THIRD_ORDER_LOWPASS_THREE_AXIS_CORE_MACROS_SVH
`define IIR_THIRD_ORDER_LOWPASS_THREE_AXIS_CORE_MACROS_SVH

// Same-cycle implication.
`define IIR3LP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define IIR3LP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: design/iir3lp_pkg.sv
// ----------------------------------------------------------------------------
// iir3lp_pkg
// Widths, coefficient register codes and reset values for the filter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package iir3lp_pkg;

	localparam int SAMPLE_WIDTH   = 32;
	localparam int COEF_WIDTH     = 32;
	localparam int COEF_FRAC_BITS = 28;
	localparam int NUM_AXES       = 3;
	localparam int NUM_TAPS       = 3;
	localparam int PROD_WIDTH     = SAMPLE_WIDTH + COEF_WIDTH;
	// seven products need three guard bits
	localparam int ACC_WIDTH      = PROD_WIDTH + 3;
	localparam int CFG_IDX_WIDTH  = 3;

	typedef enum logic [CFG_IDX_WIDTH-1:0] {
		COEF_A0 = 3'd0,
		COEF_A1 = 3'd1,
		COEF_A2 = 3'd2,
		COEF_A3 = 3'd3,
		COEF_B1 = 3'd4,
		COEF_B2 = 3'd5,
		COEF_B3 = 3'd6
	} coef_idx_t;

	typedef struct packed {
		logic signed [COEF_WIDTH-1:0] a0;
		logic signed [COEF_WIDTH-1:0] a1;
		logic signed [COEF_WIDTH-1:0] a2;
		logic signed [COEF_WIDTH-1:0] a3;
		logic signed [COEF_WIDTH-1:0] b1;
		logic signed [COEF_WIDTH-1:0] b2;
		logic signed [COEF_WIDTH-1:0] b3;
	} coef_set_t;

	// Butterworth defaults, Q3.28
	localparam logic signed [COEF_WIDTH-1:0] A0_RESET = 32'sd777978;
	localparam logic signed [COEF_WIDTH-1:0] A1_RESET = 32'sd2333935;
	localparam logic signed [COEF_WIDTH-1:0] A2_RESET = 32'sd2333935;
	localparam logic signed [COEF_WIDTH-1:0] A3_RESET = 32'sd777978;
	localparam logic signed [COEF_WIDTH-1:0] B1_RESET = -32'sd637291205;
	localparam logic signed [COEF_WIDTH-1:0] B2_RESET = 32'sd517907469;
	localparam logic signed [COEF_WIDTH-1:0] B3_RESET = -32'sd142827894;

endpackage

FILE: design/iir3lp_axis.sv
// ----------------------------------------------------------------------------
// iir3lp_axis
// One axis of the direct-form-I recursion: seven products, exact sum,
// floor shift by the coefficient fraction, saturate to the sample range.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module iir3lp_axis (
	input  iir3lp_pkg::coef_set_t                           coef,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      x0,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      x1,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      x2,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      x3,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      y1,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      y2,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      y3,
	output logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]      y0
);

	localparam int PW = iir3lp_pkg::PROD_WIDTH;
	localparam int AW = iir3lp_pkg::ACC_WIDTH;
	localparam int SW = iir3lp_pkg::SAMPLE_WIDTH;
	localparam int FB = iir3lp_pkg::COEF_FRAC_BITS;
	localparam int HW = AW - FB;

	logic signed [PW-1:0] p_a0, p_a1, p_a2, p_a3, p_b1, p_b2, p_b3;
	logic signed [AW-1:0] acc;
	logic        [HW-1:0] shifted;
	logic                 fits;

	function automatic logic signed [AW-1:0] ext(input logic signed [PW-1:0] p);
		return {{(AW-PW){p[PW-1]}}, p};
	endfunction

	assign p_a0 = coef.a0 * x0;
	assign p_a1 = coef.a1 * x1;
	assign p_a2 = coef.a2 * x2;
	assign p_a3 = coef.a3 * x3;
	assign p_b1 = coef.b1 * y1;
	assign p_b2 = coef.b2 * y2;
	assign p_b3 = coef.b3 * y3;

	assign acc = ext(p_a0) + ext(p_a1) + ext(p_a2) + ext(p_a3)
		- ext(p_b1) - ext(p_b2) - ext(p_b3);

	// arithmetic shift right = drop the fraction bits
	assign shifted = acc[AW-1:FB];

	// in range when every bit above the sample sign matches it
	assign fits = (shifted[HW-1:SW-1] == {(HW-SW+1){shifted[SW-1]}});

	always_comb begin
		if (fits) begin
			y0 = shifted[SW-1:0];
		end else if (shifted[HW-1]) begin
			y0 = {1'b1, {(SW-1){1'b0}}};
		end else begin
			y0 = {1'b0, {(SW-1){1'b1}}};
		end
	end

endmodule

FILE: design/iir_third_order_lowpass_three_axis_core.sv
// ----------------------------------------------------------------------------
// iir_third_order_lowpass_three_axis_core: three-axis 3rd-order IIR low-pass
// Path: an accepted input lands in the input reg, then moves to the result reg when that is free.
// Throughput: 1 item per cycle while out_ready holds; the whole recursion closes in one pass.
// Reset: histories and handshake state clear, coefficients load defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "iir_third_order_lowpass_three_axis_core_macros.svh"

module iir_third_order_lowpass_three_axis_core (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// coefficient write channel
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [iir3lp_pkg::CFG_IDX_WIDTH-1:0]          cfg_index,
	input  logic signed [iir3lp_pkg::COEF_WIDTH-1:0]      cfg_data,
	// sample input channel
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]    accel_x,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]    accel_y,
	input  logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]    accel_z,
	// filtered result channel
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]    filtered_x,
	output logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]    filtered_y,
	output logic signed [iir3lp_pkg::SAMPLE_WIDTH-1:0]    filtered_z
);

	localparam int SW = iir3lp_pkg::SAMPLE_WIDTH;
	localparam int NA = iir3lp_pkg::NUM_AXES;
	localparam int NT = iir3lp_pkg::NUM_TAPS;

	// Coefficient registers, shared by all three axes.
	iir3lp_pkg::coef_set_t coef_q;

	// Input register stage.
	logic                 s1_valid_q;
	logic signed [SW-1:0] samp_s1 [NA];

	// Per-axis history: entry k holds the value k+1 items back.
	logic signed [SW-1:0] xhist_q [NA][NT];
	logic signed [SW-1:0] yhist_q [NA][NT];

	// Result register.
	logic                 out_valid_q;
	logic signed [SW-1:0] res_q   [NA];

	logic signed [SW-1:0] y_new   [NA];
	logic                 advance;
	logic                 in_take;

	// Assertion helpers.
	logic                 res_in_hist;
	logic                 stall_out;
	logic        [2*SW-1:0] hist_head;

	// Config writes are always taken; codes past the last register drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.a0 <= iir3lp_pkg::A0_RESET;
			coef_q.a1 <= iir3lp_pkg::A1_RESET;
			coef_q.a2 <= iir3lp_pkg::A2_RESET;
			coef_q.a3 <= iir3lp_pkg::A3_RESET;
			coef_q.b1 <= iir3lp_pkg::B1_RESET;
			coef_q.b2 <= iir3lp_pkg::B2_RESET;
			coef_q.b3 <= iir3lp_pkg::B3_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (iir3lp_pkg::coef_idx_t'(cfg_index))
				iir3lp_pkg::COEF_A0: coef_q.a0 <= cfg_data;
				iir3lp_pkg::COEF_A1: coef_q.a1 <= cfg_data;
				iir3lp_pkg::COEF_A2: coef_q.a2 <= cfg_data;
				iir3lp_pkg::COEF_A3: coef_q.a3 <= cfg_data;
				iir3lp_pkg::COEF_B1: coef_q.b1 <= cfg_data;
				iir3lp_pkg::COEF_B2: coef_q.b2 <= cfg_data;
				iir3lp_pkg::COEF_B3: coef_q.b3 <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Advance the staged item into the result register whenever that
	// register is empty or being drained this cycle. The input stage
	// refills in the same cycle, so items stream at one per clock while out_ready holds.
	assign advance  = s1_valid_q && (!out_valid_q || out_ready);
	assign in_ready = !s1_valid_q || advance;
	assign in_take  = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_take) begin
			s1_valid_q <= 1'b1;
		end else if (advance) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Capture the sample payload; no reset needed.
	always_ff @(posedge clk) begin
		if (in_take) begin
			samp_s1[0] <= accel_x;
			samp_s1[1] <= accel_y;
			samp_s1[2] <= accel_z;
		end
	end

	// One datapath per axis, all fed from the staged sample and history.
	for (genvar a = 0; a < NA; a++) begin : g_axis
		iir3lp_axis u_axis (
			.coef (coef_q),
			.x0   (samp_s1[a]),
			.x1   (xhist_q[a][0]),
			.x2   (xhist_q[a][1]),
			.x3   (xhist_q[a][2]),
			.y1   (yhist_q[a][0]),
			.y2   (yhist_q[a][1]),
			.y3   (yhist_q[a][2]),
			.y0   (y_new[a])
		);
	end

	// Shift the histories only when an item actually leaves the input
	// stage; the saturated output is what gets fed back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int a = 0; a < NA; a++) begin
				for (int k = 0; k < NT; k++) begin
					xhist_q[a][k] <= '0;
					yhist_q[a][k] <= '0;
				end
			end
		end else if (advance) begin
			for (int a = 0; a < NA; a++) begin
				xhist_q[a][0] <= samp_s1[a];
				yhist_q[a][0] <= y_new[a];
				for (int k = 1; k < NT; k++) begin
					xhist_q[a][k] <= xhist_q[a][k-1];
					yhist_q[a][k] <= yhist_q[a][k-1];
				end
			end
		end
	end

	// Result register: load on advance, drop once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			for (int a = 0; a < NA; a++) begin
				res_q[a] <= y_new[a];
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign filtered_x = res_q[0];
	assign filtered_y = res_q[1];
	assign filtered_z = res_q[2];

	assign res_in_hist = (res_q[0] == yhist_q[0][0]) && (res_q[1] == yhist_q[1][0])
		&& (res_q[2] == yhist_q[2][0]);
	assign stall_out   = out_valid_q && !out_ready;
	assign hist_head   = {xhist_q[0][0], yhist_q[0][0]};

	// The pending result is always the newest feedback value.
	`IIR3LP_ASSERT_NOW(a_res_matches_hist, out_valid_q, res_in_hist, "result not in history")

	// A stalled result must freeze the recursion.
	`IIR3LP_ASSERT_NEXT(a_stall_holds_hist, stall_out, $stable(hist_head), "history moved on stall")

	// Every advance lands a valid result.
	`IIR3LP_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_q, "advanced item lost")

endmodule

FILE: tb/tb_iir_third_order_lowpass_three_axis_core.sv
// ----------------------------------------------------------------------------
// tb_iir_third_order_lowpass_three_axis_core: self-checking bench
// Drives three-axis samples and coefficient writes through valid/ready
// channels. A bit-exact filter predictor computes each item's result, and
// every result is checked field by field in arrival order. The run starts
// with a directed table and continues with random samples under changing
// coefficient sets and idle/stall mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_iir_third_order_lowpass_three_axis_core;

	localparam int SAMPLE_WIDTH   = iir3lp_pkg::SAMPLE_WIDTH;
	localparam int COEF_WIDTH     = iir3lp_pkg::COEF_WIDTH;
	localparam int COEF_FRAC_BITS = iir3lp_pkg::COEF_FRAC_BITS;
	localparam int NUM_AXES       = iir3lp_pkg::NUM_AXES;
	localparam int NUM_TAPS       = iir3lp_pkg::NUM_TAPS;
	localparam int CFG_IDX_WIDTH  = iir3lp_pkg::CFG_IDX_WIDTH;

	localparam int CLK_PERIOD    = 10;
	localparam int SETTLE_CYCLES = 6;       // pipeline is two deep; leave margin
	localparam int CYCLE_LIMIT   = 200000;
	localparam int SEG_ITEMS     = 50;      // random items per coefficient set
	localparam int SUM_W         = 2 * SAMPLE_WIDTH + 32;  // exact sum, lots of headroom

	localparam logic [CFG_IDX_WIDTH-1:0] CFG_IDX_SPARE = 3'd7;  // decoded by nothing

	localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX   = 32'sh7fff_ffff;
	localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN   = 32'sh8000_0000;
	localparam logic signed [SAMPLE_WIDTH-1:0] Q16_ONE = 32'sh0001_0000;
	localparam logic signed [COEF_WIDTH-1:0]   Q28_ONE = 32'sh1000_0000;
	localparam logic signed [COEF_WIDTH-1:0]   C_MAX   = 32'sh7fff_ffff;
	localparam logic signed [COEF_WIDTH-1:0]   C_MIN   = 32'sh8000_0000;

	// Coefficient sets the directed table and the random part can load.
	typedef enum {
		KEEP, BUTTERWORTH, UNITY_GAIN, GAIN_MAX, GAIN_MIN, RUNNING_SUM, ALL_MAX, ALL_MIN
	} preset_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] x;
		logic signed [SAMPLE_WIDTH-1:0] y;
		logic signed [SAMPLE_WIDTH-1:0] z;
	} triple_t;

	typedef struct {
		preset_t coefs;   // set to load before the item, KEEP for none
		triple_t stim;
		bit      known;   // result typed in below instead of predicted
		triple_t want;
	} vector_t;

	logic                              clk       = 1'b0;
	logic                              arst_n    = 1'b0;
	logic                              cfg_valid = 1'b0;
	logic                              cfg_ready;
	logic [CFG_IDX_WIDTH-1:0]          cfg_index = '0;
	logic signed [COEF_WIDTH-1:0]      cfg_data  = '0;
	logic                              in_valid  = 1'b0;
	logic                              in_ready;
	logic signed [SAMPLE_WIDTH-1:0]    accel_x   = '0;
	logic signed [SAMPLE_WIDTH-1:0]    accel_y   = '0;
	logic signed [SAMPLE_WIDTH-1:0]    accel_z   = '0;
	logic                              out_valid;
	logic                              out_ready = 1'b0;
	logic signed [SAMPLE_WIDTH-1:0]    filtered_x;
	logic signed [SAMPLE_WIDTH-1:0]    filtered_y;
	logic signed [SAMPLE_WIDTH-1:0]    filtered_z;

	// Predictor state: coefficients plus three taps of input and output per axis.
	logic signed [COEF_WIDTH-1:0]      coef_q [0:6];
	logic signed [SAMPLE_WIDTH-1:0]    x_hist [0:NUM_AXES-1][0:NUM_TAPS-1];
	logic signed [SAMPLE_WIDTH-1:0]    y_hist [0:NUM_AXES-1][0:NUM_TAPS-1];

	triple_t     pending_filtered [$];  // results owed by the block, oldest first
	vector_t     directed_q [$];

	int          idle_pct  = 0;
	int          stall_pct = 0;
	int          error_count;
	int          items_sent;
	int          results_seen;
	int          cfg_writes;
	int          coef_sets;
	int unsigned cycle_count;

	iir_third_order_lowpass_three_axis_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.accel_x    (accel_x),
		.accel_y    (accel_y),
		.accel_z    (accel_z),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.filtered_x (filtered_x),
		.filtered_y (filtered_y),
		.filtered_z (filtered_z)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------------

	task automatic filter_reset();
		coef_q[iir3lp_pkg::COEF_A0] = iir3lp_pkg::A0_RESET;
		coef_q[iir3lp_pkg::COEF_A1] = iir3lp_pkg::A1_RESET;
		coef_q[iir3lp_pkg::COEF_A2] = iir3lp_pkg::A2_RESET;
		coef_q[iir3lp_pkg::COEF_A3] = iir3lp_pkg::A3_RESET;
		coef_q[iir3lp_pkg::COEF_B1] = iir3lp_pkg::B1_RESET;
		coef_q[iir3lp_pkg::COEF_B2] = iir3lp_pkg::B2_RESET;
		coef_q[iir3lp_pkg::COEF_B3] = iir3lp_pkg::B3_RESET;
		for (int a = 0; a < NUM_AXES; a++) begin
			for (int k = 0; k < NUM_TAPS; k++) begin
				x_hist[a][k] = '0;
				y_hist[a][k] = '0;
			end
		end
	endtask

	function automatic triple_t xyz(logic signed [SAMPLE_WIDTH-1:0] a,
			logic signed [SAMPLE_WIDTH-1:0] b, logic signed [SAMPLE_WIDTH-1:0] c);
		triple_t t;
		t.x = a;
		t.y = b;
		t.z = c;
		return t;
	endfunction

	// Advance all three axes by one sample and return the filtered item.
	function automatic triple_t filter_step(triple_t s);
		logic signed [SAMPLE_WIDTH-1:0] xin [0:NUM_AXES-1];
		logic signed [SAMPLE_WIDTH-1:0] yout [0:NUM_AXES-1];
		logic signed [SUM_W-1:0]        acc;
		logic signed [SUM_W-1:0]        scaled;
		xin[0] = s.x;
		xin[1] = s.y;
		xin[2] = s.z;
		for (int a = 0; a < NUM_AXES; a++) begin
			// all operands signed, so each product is sign-extended to SUM_W first
			acc = coef_q[iir3lp_pkg::COEF_A0] * xin[a];
			for (int k = 0; k < NUM_TAPS; k++) begin
				acc = acc + coef_q[iir3lp_pkg::COEF_A1 + k] * x_hist[a][k];
				acc = acc - coef_q[iir3lp_pkg::COEF_B1 + k] * y_hist[a][k];
			end
			// arithmetic shift floors; clamp anything outside the sample range
			scaled = acc >>> COEF_FRAC_BITS;
			if (scaled[SUM_W-1:SAMPLE_WIDTH-1] != {(SUM_W-SAMPLE_WIDTH+1){scaled[SUM_W-1]}}) begin
				yout[a] = scaled[SUM_W-1] ? S_MIN : S_MAX;
			end else begin
				yout[a] = scaled[SAMPLE_WIDTH-1:0];
			end
			// the clamped value is what feeds back
			for (int k = NUM_TAPS - 1; k > 0; k--) begin
				x_hist[a][k] = x_hist[a][k-1];
				y_hist[a][k] = y_hist[a][k-1];
			end
			x_hist[a][0] = xin[a];
			y_hist[a][0] = yout[a];
		end
		return xyz(yout[0], yout[1], yout[2]);
	endfunction

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	function automatic iir3lp_pkg::coef_set_t preset_coefs(preset_t p);
		iir3lp_pkg::coef_set_t c;
		c = '0;
		case (p)
			BUTTERWORTH: begin
				c.a0 = iir3lp_pkg::A0_RESET;
				c.a1 = iir3lp_pkg::A1_RESET;
				c.a2 = iir3lp_pkg::A2_RESET;
				c.a3 = iir3lp_pkg::A3_RESET;
				c.b1 = iir3lp_pkg::B1_RESET;
				c.b2 = iir3lp_pkg::B2_RESET;
				c.b3 = iir3lp_pkg::B3_RESET;
			end
			UNITY_GAIN:  c.a0 = Q28_ONE;
			GAIN_MAX:    c.a0 = C_MAX;
			GAIN_MIN:    c.a0 = C_MIN;
			RUNNING_SUM: begin
				// y = x + previous y: drives the output into the rails and keeps it there
				c.a0 = Q28_ONE;
				c.b1 = -Q28_ONE;
			end
			ALL_MAX:     c = {7{C_MAX}};
			ALL_MIN:     c = {7{C_MIN}};
			default:     c = '0;
		endcase
		return c;
	endfunction

	function automatic iir3lp_pkg::coef_set_t random_coefs();
		logic signed [COEF_WIDTH-1:0] pick [0:6];
		logic [31:0]                  r;
		int                           mode;
		mode = $urandom_range(3);
		if (mode == 3) begin
			return preset_coefs(BUTTERWORTH);
		end
		for (int k = 0; k < 7; k++) begin
			r = $urandom;
			case (mode)
				0: pick[k] = r;                         // anything, mostly unstable
				1: begin
					case ($urandom_range(5))
						0:       pick[k] = '0;
						1:       pick[k] = C_MAX;
						2:       pick[k] = C_MIN;
						3:       pick[k] = Q28_ONE;
						4:       pick[k] = -Q28_ONE;
						default: pick[k] = r;
					endcase
				end
				default: pick[k] = {{6{r[25]}}, r[25:0]};  // within +-1/8, tame feedback
			endcase
		end
		return {pick[0], pick[1], pick[2], pick[3], pick[4], pick[5], pick[6]};
	endfunction

	function automatic logic signed [SAMPLE_WIDTH-1:0] random_sample();
		logic [31:0] r;
		r = $urandom;
		case ($urandom_range(7))
			0: begin
				case ($urandom_range(3))
					0:       return S_MAX;
					1:       return S_MIN;
					2:       return '0;
					default: return -1;
				endcase
			end
			1, 2, 3: return r;
			default: return {{12{r[19]}}, r[19:0]};  // plausible sensor range
		endcase
	endfunction

	task automatic report_mismatch(string msg);
		error_count++;
		if (error_count <= 30) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
	endtask

	// Drop valid, wait for every owed result, then let the pipeline settle.
	task automatic hold_until_drained();
		in_valid <= 1'b0;
		while (pending_filtered.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_coef(logic [CFG_IDX_WIDTH-1:0] idx, logic signed [COEF_WIDTH-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		if (idx <= iir3lp_pkg::COEF_B3) begin
			coef_q[idx] = data;
		end
		cfg_writes++;
	endtask

	// Write all seven coefficients with the block idle, then poke the unused index.
	task automatic load_coefs(iir3lp_pkg::coef_set_t c);
		hold_until_drained();
		for (int k = iir3lp_pkg::COEF_A0; k <= iir3lp_pkg::COEF_B3; k++) begin
			write_coef(CFG_IDX_WIDTH'(k),
				c[(iir3lp_pkg::COEF_B3 - k) * COEF_WIDTH +: COEF_WIDTH]);
		end
		write_coef(CFG_IDX_SPARE, $urandom);
		cfg_valid <= 1'b0;
		coef_sets++;
	endtask

	// Offer one item, idling first at the current rate; predict once accepted.
	// Valid stays high on return so a back-to-back item needs no extra edge.
	task automatic send_sample(triple_t s, bit known, triple_t typed);
		triple_t want;
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid <= 1'b1;
		accel_x  <= s.x;
		accel_y  <= s.y;
		accel_z  <= s.z;
		do @(posedge clk); while (!in_ready);
		want = filter_step(s);
		if (known) begin
			want = typed;
		end
		pending_filtered.push_back(want);
		items_sent++;
	endtask

	// ------------------------------------------------------------------------
	// Result side: random back-pressure and in-order checking
	// ------------------------------------------------------------------------

	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin : check_results
		triple_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (pending_filtered.size() == 0) begin
				report_mismatch($sformatf("result %0d/%0d/%0d with no sample pending",
					filtered_x, filtered_y, filtered_z));
			end else begin
				want = pending_filtered.pop_front();
				if (filtered_x !== want.x) begin
					report_mismatch($sformatf("result %0d filtered_x got %0d want %0d",
						results_seen, filtered_x, want.x));
				end
				if (filtered_y !== want.y) begin
					report_mismatch($sformatf("result %0d filtered_y got %0d want %0d",
						results_seen, filtered_y, want.y));
				end
				if (filtered_z !== want.z) begin
					report_mismatch($sformatf("result %0d filtered_z got %0d want %0d",
						results_seen, filtered_z, want.z));
				end
			end
		end
	end

	// Hard stop in case the block hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles with %0d results outstanding",
				cycle_count, pending_filtered.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------

	initial begin : stimulus
		triple_t s;
		preset_t closing_set [0:3];
		int      idle_mix [0:3];
		int      stall_mix [0:3];

		// Directed table. Typed results: zero in gives zero out after reset;
		// unity gain passes samples through; a lone a0 at either rail
		// saturates extremes and floors small inputs (-1 * ~8.0 gives -8).
		directed_q.push_back('{KEEP, xyz(0, 0, 0), 1'b1, xyz(0, 0, 0)});
		directed_q.push_back('{KEEP, xyz(S_MAX, S_MIN, Q16_ONE), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{KEEP, xyz(S_MIN, S_MAX, -1), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{KEEP, xyz(0, 0, 0), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{KEEP, xyz(Q16_ONE, -Q16_ONE, 32'sh1234_5678), 1'b0,
			xyz(0, 0, 0)});
		directed_q.push_back('{UNITY_GAIN, xyz(S_MAX, S_MIN, -1), 1'b1, xyz(S_MAX, S_MIN, -1)});
		directed_q.push_back('{KEEP, xyz(Q16_ONE, 32'sh1234_5678, 32'sh8000_0001), 1'b1,
			xyz(Q16_ONE, 32'sh1234_5678, 32'sh8000_0001)});
		directed_q.push_back('{GAIN_MAX, xyz(S_MAX, S_MIN, 1), 1'b1, xyz(S_MAX, S_MIN, 7)});
		directed_q.push_back('{KEEP, xyz(-1, 0, 32'sh1000_0000), 1'b1, xyz(-8, 0, S_MAX)});
		directed_q.push_back('{GAIN_MIN, xyz(S_MIN, S_MAX, 1), 1'b1, xyz(S_MAX, S_MIN, -8)});
		directed_q.push_back('{KEEP, xyz(-1, 0, 32'sh1000_0000), 1'b1, xyz(8, 0, S_MIN)});
		// Running sum: outputs hit the rails and the clamped value feeds back.
		for (int i = 0; i < 4; i++) begin
			directed_q.push_back('{(i == 0) ? RUNNING_SUM : KEEP,
				xyz(32'sh4000_0000, 32'shc000_0000, Q16_ONE), 1'b0, xyz(0, 0, 0)});
		end
		directed_q.push_back('{KEEP, xyz(S_MIN, S_MAX, 0), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{ALL_MAX, xyz(S_MAX, S_MAX, S_MAX), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{KEEP, xyz(S_MIN, S_MIN, S_MIN), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{ALL_MIN, xyz(S_MAX, S_MIN, Q16_ONE), 1'b0, xyz(0, 0, 0)});
		directed_q.push_back('{KEEP, xyz(0, 0, 0), 1'b0, xyz(0, 0, 0)});
		// Back to the stock filter: step response from a dirty history.
		for (int i = 0; i < 3; i++) begin
			directed_q.push_back('{(i == 0) ? BUTTERWORTH : KEEP,
				xyz(Q16_ONE, -Q16_ONE, 32'sh0100_0000), 1'b0, xyz(0, 0, 0)});
		end

		closing_set = '{BUTTERWORTH, ALL_MAX, ALL_MIN, RUNNING_SUM};
		idle_mix    = '{0, 82, 0, 14};
		stall_mix   = '{0, 0, 82, 14};

		filter_reset();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed rows under light idling on both sides.
		idle_pct  = 14;
		stall_pct = 14;
		foreach (directed_q[i]) begin
			if (directed_q[i].coefs != KEEP) begin
				load_coefs(preset_coefs(directed_q[i].coefs));
			end
			send_sample(directed_q[i].stim, directed_q[i].known, directed_q[i].want);
		end

		// Random part: each idle/stall mix runs three coefficient sets.
		for (int ph = 0; ph < 4; ph++) begin
			for (int seg = 0; seg < 3; seg++) begin
				// reload with the block drained, then apply the new traffic mix
				load_coefs((seg == 2) ? preset_coefs(closing_set[ph]) : random_coefs());
				idle_pct  = idle_mix[ph];
				stall_pct = stall_mix[ph];
				s = xyz(random_sample(), random_sample(), random_sample());
				for (int i = 0; i < SEG_ITEMS; i++) begin
					// hold the previous sample now and then to let the filter settle
					if ($urandom_range(3) != 0) begin
						s = xyz(random_sample(), random_sample(), random_sample());
					end
					send_sample(s, 1'b0, s);
				end
			end
		end

		// Drain, then keep watching through the settle time for anything unexpected.
		stall_pct = 0;
		hold_until_drained();

		$display("Covered %0d samples (%0d from the directed table), %0d results checked,",
			items_sent, directed_q.size(), results_seen);
		$display("%0d coefficient sets via %0d register writes, under four idle/stall mixes.",
			coef_sets, cfg_writes);
		if (error_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+design
design/iir3lp_pkg.sv
design/iir3lp_axis.sv
design/iir_third_order_lowpass_three_axis_core.sv
tb/tb_iir_third_order_lowpass_three_axis_core.sv
